FILE: rtl/core/line_sensor_calibrate_and_centroid_top_assert.svh
// assertion macros for the line sensor block
`ifndef LINE_SENSOR_CALIBRATE_AND_CENTROID_TOP_ASSERT_SVH
`define LINE_SENSOR_CALIBRATE_AND_CENTROID_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LSC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LSC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LSC_ASSERT_CLK(lbl, prop, msg)
`define LSC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: rtl/core/lsc_pkg.sv
package lsc_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int SAMPLE_BITS  = 10;
	localparam int LANES_MAX    = 8;
	localparam int LANES        = (SENSOR_COUNT < LANES_MAX) ? SENSOR_COUNT : LANES_MAX;
	localparam int FIELD_BITS   = 10;
	localparam int OP_BITS      = 2;
	localparam int POS_BITS     = 13;
	localparam int PATTERN_BITS = 8;
	localparam int INDEX_WEIGHT = 1000;
	localparam int NO_LINE_POS  = 3500;

	localparam int WSUM_MAX    = INDEX_WEIGHT * LANES * (LANES - 1) / 2;
	localparam int WSUM_BITS   = $clog2(WSUM_MAX + 1);
	localparam int COUNT_BITS  = $clog2(LANES + 1);
	localparam int SEL_BITS    = $clog2(LANES_MAX + 1);
	localparam int RECIP_SHIFT = $clog2(WSUM_MAX * LANES + 1) + 1;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int PROD_BITS   = WSUM_BITS + RECIP_BITS;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// ceil(2^shift / n), exact for every weighted sum this block can form
	localparam logic [RECIP_BITS-1:0] RECIP_1 = RECIP_BITS'(((1 << RECIP_SHIFT) + 0) / 1);
	localparam logic [RECIP_BITS-1:0] RECIP_2 = RECIP_BITS'(((1 << RECIP_SHIFT) + 1) / 2);
	localparam logic [RECIP_BITS-1:0] RECIP_3 = RECIP_BITS'(((1 << RECIP_SHIFT) + 2) / 3);
	localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'(((1 << RECIP_SHIFT) + 3) / 4);
	localparam logic [RECIP_BITS-1:0] RECIP_5 = RECIP_BITS'(((1 << RECIP_SHIFT) + 4) / 5);
	localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'(((1 << RECIP_SHIFT) + 5) / 6);
	localparam logic [RECIP_BITS-1:0] RECIP_7 = RECIP_BITS'(((1 << RECIP_SHIFT) + 6) / 7);
	localparam logic [RECIP_BITS-1:0] RECIP_8 = RECIP_BITS'(((1 << RECIP_SHIFT) + 7) / 8);

	localparam logic [OP_BITS-1:0] OP_CLEAR     = 2'd0;
	localparam logic [OP_BITS-1:0] OP_CALIBRATE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_MEASURE   = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR     = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_MEASURE   = 2'd2
	} cmd_kind_t;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [LANES-1:0] lane_samples_t;

	typedef struct packed {
		cmd_kind_t     kind;
		lane_samples_t samples;
	} cmd_t;

	typedef struct packed {
		logic [OP_BITS-1:0]    op;
		logic [FIELD_BITS-1:0] sample_0;
		logic [FIELD_BITS-1:0] sample_1;
		logic [FIELD_BITS-1:0] sample_2;
		logic [FIELD_BITS-1:0] sample_3;
		logic [FIELD_BITS-1:0] sample_4;
		logic [FIELD_BITS-1:0] sample_5;
		logic [FIELD_BITS-1:0] sample_6;
		logic [FIELD_BITS-1:0] sample_7;
	} in_word_t;

	typedef struct packed {
		logic [POS_BITS-1:0]     position;
		logic                    line_seen;
		logic [PATTERN_BITS-1:0] active_pattern;
	} out_word_t;

	function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] n);
		logic [SEL_BITS-1:0] sel;
		logic [RECIP_BITS-1:0] r;
		sel = SEL_BITS'(n);
		case (sel)
			SEL_BITS'(1): r = RECIP_1;
			SEL_BITS'(2): r = RECIP_2;
			SEL_BITS'(3): r = RECIP_3;
			SEL_BITS'(4): r = RECIP_4;
			SEL_BITS'(5): r = RECIP_5;
			SEL_BITS'(6): r = RECIP_6;
			SEL_BITS'(7): r = RECIP_7;
			SEL_BITS'(8): r = RECIP_8;
			default:      r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/lsc_front.sv
module lsc_front (
	input  lsc_pkg::in_word_t scan,
	input  logic              scan_valid,
	output logic              scan_stall,
	input  logic              queue_full,
	output logic              push,
	output lsc_pkg::cmd_t     push_cmd
);
	import lsc_pkg::*;

	logic [LANES_MAX-1:0][FIELD_BITS-1:0] fields;
	logic                                 known;

	assign fields = {scan.sample_7, scan.sample_6, scan.sample_5, scan.sample_4,
		scan.sample_3, scan.sample_2, scan.sample_1, scan.sample_0};

	always_comb begin
		known = 1'b1;
		push_cmd.kind = CMD_CLEAR;
		case (scan.op)
			OP_CLEAR:     push_cmd.kind = CMD_CLEAR;
			OP_CALIBRATE: push_cmd.kind = CMD_CALIBRATE;
			OP_MEASURE:   push_cmd.kind = CMD_MEASURE;
			default:      known = 1'b0;
		endcase
		for (int i = 0; i < LANES; i++) begin
			push_cmd.samples[i] = SAMPLE_BITS'(fields[i]);
		end
	end

	// unknown ops are taken and dropped
	assign scan_stall = queue_full;
	assign push       = scan_valid && !queue_full && known;

endmodule

FILE: rtl/core/lsc_queue.sv
`include "line_sensor_calibrate_and_centroid_top_assert.svh"

module lsc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lsc_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output lsc_pkg::cmd_t head
);
	import lsc_pkg::*;

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QCOUNT_BITS-1:0] count_q;

	function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
		return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCOUNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`LSC_ASSERT_NEVER(a_queue_overflow, push && full && !pop, "word pushed into a full queue")
	`LSC_ASSERT_NEVER(a_queue_underflow, pop && !head_valid, "pop from an empty queue")

endmodule

FILE: rtl/core/lsc_back.sv
`include "line_sensor_calibrate_and_centroid_top_assert.svh"

module lsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  lsc_pkg::cmd_t      head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output lsc_pkg::out_word_t result
);
	import lsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_RES  = 3'b100
	} state_t;

	state_t                state_q;
	sample_t               min_q [LANES];
	sample_t               max_q [LANES];
	logic [LANES-1:0]      pattern_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [WSUM_BITS-1:0]  wsum_q;
	logic [PROD_BITS-1:0]  prod_q;
	out_word_t             result_q;
	logic                  result_valid_q;

	logic [SAMPLE_BITS:0]  mid_sum [LANES];
	logic [LANES-1:0]      hit;
	logic [COUNT_BITS-1:0] hit_count;
	logic [WSUM_BITS-1:0]  hit_sum;
	logic                  load;

	always_comb begin
		hit_count = '0;
		hit_sum   = '0;
		for (int i = 0; i < LANES; i++) begin
			mid_sum[i] = {1'b0, min_q[i]} + {1'b0, max_q[i]};
			hit[i]     = ({1'b0, head.samples[i]} <= (mid_sum[i] >> 1));
			hit_count  = hit_count + COUNT_BITS'(hit[i]);
			hit_sum    = hit_sum + (hit[i] ? WSUM_BITS'(i * INDEX_WEIGHT) : '0);
		end
	end

	assign pop  = (state_q == ST_IDLE) && head_valid;
	assign load = (state_q == ST_RES) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else begin
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.kind)
							CMD_CLEAR: begin
								for (int i = 0; i < LANES; i++) begin
									min_q[i] <= '1;
									max_q[i] <= '0;
								end
							end
							CMD_CALIBRATE: begin
								for (int i = 0; i < LANES; i++) begin
									if (head.samples[i] < min_q[i]) begin
										min_q[i] <= head.samples[i];
									end
									if (head.samples[i] > max_q[i]) begin
										max_q[i] <= head.samples[i];
									end
								end
							end
							CMD_MEASURE: state_q <= ST_MUL;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL: state_q <= ST_RES;
				ST_RES: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == CMD_MEASURE) begin
			pattern_q <= hit;
			count_q   <= hit_count;
			wsum_q    <= hit_sum;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_BITS'(wsum_q) * PROD_BITS'(recip(count_q));
		end
		if (load) begin
			result_q.position       <= (count_q == '0) ? POS_BITS'(NO_LINE_POS)
				: POS_BITS'(prod_q >> RECIP_SHIFT);
			result_q.line_seen      <= (count_q != '0);
			result_q.active_pattern <= PATTERN_BITS'(pattern_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`LSC_ASSERT_CLK(a_seen_matches_pattern, result_valid |-> (result.line_seen == (result.active_pattern != '0)), "line_seen disagrees with pattern")
	`LSC_ASSERT_CLK(a_no_line_center, (result_valid && !result.line_seen) |-> (result.position == POS_BITS'(NO_LINE_POS)), "empty scan not centered")
	`LSC_ASSERT_CLK(a_position_range, (result_valid && result.line_seen) |-> (result.position <= POS_BITS'(INDEX_WEIGHT * (LANES - 1))), "position beyond last sensor")
	`LSC_ASSERT_CLK(a_mul_then_result, (state_q == ST_MUL) |=> (state_q == ST_RES), "multiply step not followed by result step")

endmodule

FILE: rtl/core/line_sensor_calibrate_and_centroid_top.sv
// Line sensor calibration and position. Each scan word carries an op and eight
// 10-bit samples. Clear and calibrate words update the per-channel min/max and
// return nothing; a measure word returns the active-sensor pattern, line_seen
// and the mean of 1000 * index over active sensors (3500 when none). A two-word
// queue sits between the input and the execution unit, so scans are taken while
// a result waits. Clear and calibrate retire as they are popped; a measure
// passes through compare, reciprocal multiply and result register, plus output
// wait. The execution unit runs these three steps one after another without
// overlap, so it pops no new word until a measure's result is registered.
module line_sensor_calibrate_and_centroid_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               scan_valid,
	output logic               scan_stall,
	input  lsc_pkg::in_word_t  scan,
	output logic               result_valid,
	input  logic               result_stall,
	output lsc_pkg::out_word_t result
);
	import lsc_pkg::*;

	logic queue_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	lsc_front u_front (
		.scan       (scan),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
